// ===== rtl/core/vta_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Virtual tick accounting package
// Shared types, codes and constants of the virtual tick time accounting block.
// ----------------------------------------------------------------------------
package vta_pkg;

	localparam int unsigned NS_W     = 64;
	localparam int unsigned PERIOD_W = 24;
	localparam int unsigned JITTER_W = 32;
	localparam int unsigned COUNT_W  = 32;
	localparam int unsigned FRAC_W   = 32;
	localparam int unsigned SHIFT_W  = 6;
	localparam int unsigned STEP_W   = $clog2(NS_W);

	localparam logic [PERIOD_W-1:0] TICK_PERIOD_RESET = 24'd10000000;
	localparam logic [JITTER_W-1:0] JITTER_RESET      = 32'd10000000;

	localparam logic CFG_TICK_PERIOD = 1'b0;
	localparam logic CFG_JITTER      = 1'b1;

	localparam logic OP_TIMER = 1'b0;
	localparam logic OP_INIT  = 1'b1;

	// Input tdata layout, lowest bit first.
	localparam int unsigned IN_CYCLE_NOW   = 0;
	localparam int unsigned IN_CYCLE_STAMP = 64;
	localparam int unsigned IN_SYS_STAMP   = 128;
	localparam int unsigned IN_FRAC        = 192;
	localparam int unsigned IN_SHIFT       = 224;
	localparam int unsigned IN_RUNNABLE    = 230;
	localparam int unsigned IN_BLOCKED     = 294;
	localparam int unsigned IN_USER        = 358;
	localparam int unsigned IN_DATA_W      = 360;

	localparam int unsigned OUT_DATA_W = 136;

	typedef enum logic {
		ALU_ADD,
		ALU_SUB
	} alu_op_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/vta_alu.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Virtual tick accounting shared adder
// 64-bit add and subtract unit with a signed less-than flag for subtraction.
// ----------------------------------------------------------------------------
module vta_alu
	import vta_pkg::*;
(
	input  wire alu_op_t         op,
	input  wire logic [NS_W-1:0] a,
	input  wire logic [NS_W-1:0] b,
	output logic [NS_W-1:0]      y,
	output logic                 lt
);

	always_comb begin
		unique case (op)
			ALU_ADD: y = a + b;
			ALU_SUB: y = a - b;
			default: y = a + b;
		endcase
		lt = (a[NS_W-1] ^ b[NS_W-1]) ? a[NS_W-1] : y[NS_W-1];
	end

endmodule

`default_nettype wire

// ===== rtl/core/vta_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Virtual tick accounting divider
// Restoring divider, one quotient bit per cycle, 64 by 24 bits.
// ----------------------------------------------------------------------------
module vta_div
	import vta_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic [NS_W-1:0]     dividend,
	input  wire logic [PERIOD_W-1:0] divisor,
	output logic [NS_W-1:0]          quotient,
	output logic [PERIOD_W-1:0]      remainder,
	output div_sts_t                 sts
);

	logic [NS_W-1:0]     dvd_q;
	logic [PERIOD_W-1:0] rem_q;
	logic [STEP_W-1:0]   cnt_q;
	logic                busy_q;
	logic                done_q;
	logic [PERIOD_W:0]   trial;
	logic                fits;

	always_comb begin
		trial = {rem_q, dvd_q[NS_W-1]};
		fits  = trial >= {1'b0, divisor};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == STEP_W'(NS_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[NS_W-2:0], fits};
			rem_q <= fits ? PERIOD_W'(trial - {1'b0, divisor}) : trial[PERIOD_W-1:0];
		end
	end

	assign quotient  = dvd_q;
	assign remainder = rem_q;
	assign sts.busy  = busy_q;
	assign sts.done  = done_q;

endmodule

`default_nettype wire

// ===== rtl/core/virtual_tick_time_accounting.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Virtual tick time accounting
// Turns a timer event into global, stolen, blocked and busy tick counts.
// ----------------------------------------------------------------------------
// The input stream carries one timer event or init command per transaction;
// s_axis_tuser holds the opcode. Every transaction yields one result on the
// output stream. The configuration channel writes the tick period and the
// jitter limit; it is always ready, and the user must write it only while
// the block idles; the block itself does not enforce this. An init command
// goes straight to the done state. For a timer event the cycle delta is
// shifted and scaled with one 32x32 multiplier used twice, all 64-bit sums
// run through one shared adder, and up to four 64-step divisions by the
// tick period run on one restoring divider. One item is worked on at a
// time; s_axis_tready is high only while the sequencer is idle, so a new
// item is accepted at the earliest in the cycle after the previous result
// is written. A finished result waits in the output register while the
// next item is accepted; a result behind a stalled output waits before it
// is written. Reset clears the processed counters, loads the default
// period and jitter limit and empties the output.
// ----------------------------------------------------------------------------
module virtual_tick_time_accounting
	import vta_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	// cycle_now, cycle_stamp, system_stamp_ns, scale_fraction, scale_shift,
	// runnable_offline_ns, blocked_total_ns, in_user_mode, zero pad
	input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
	// opcode
	input  wire logic                  s_axis_tuser,
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	// global_ticks, stolen_ticks, blocked_ticks, busy_ticks, busy_is_user,
	// went_backwards, zero pad
	output logic [OUT_DATA_W-1:0]      m_axis_tdata,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic                  cfg_index,
	input  wire logic [JITTER_W-1:0]   cfg_data
);

	typedef enum logic [4:0] {
		ST_IDLE, ST_DIFF, ST_SHIFT, ST_MLO, ST_MHI, ST_SCALE, ST_NOW,
		ST_DELTA, ST_DCPU, ST_STOL, ST_BLKD, ST_LIM, ST_BK1, ST_BK2,
		ST_CHK, ST_DSUB, ST_DIV, ST_WAIT, ST_INC, ST_ACC1, ST_ACC2, ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		SH_GLOBAL, SH_STOLEN, SH_BLOCKED, SH_BUSY
	} share_t;

	state_t               state_q;
	share_t               share_q;
	logic [PERIOD_W-1:0]  period_q;
	logic [JITTER_W-1:0]  jitter_q;
	logic [NS_W-1:0]      glob_q, loc_q, pst_q, pbl_q;
	logic [IN_DATA_W-1:0] in_q;
	logic [NS_W-1:0]      d_q, prod_q, now_q, delta_q, dcpu_q, stol_q, blkd_q;
	logic [NS_W-1:0]      lim_q, take_q, inc_q;
	logic [FRAC_W-1:0]    lohi_q;
	logic [COUNT_W-1:0]   res_q [4];
	logic                 back_q;
	logic                 out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	logic [NS_W-1:0]      cyc_now, cyc_stamp, sys_stamp, runnable, blk_total;
	logic [FRAC_W-1:0]    frac;
	logic [SHIFT_W-1:0]   shamt, rsh;
	logic                 user;
	logic [NS_W-1:0]      shifted;
	logic [FRAC_W-1:0]    mul_a;
	logic [NS_W-1:0]      mul_y;
	alu_op_t              alu_op;
	logic [NS_W-1:0]      alu_a, alu_b, alu_y;
	logic                 alu_lt;
	logic [PERIOD_W-1:0]  period;
	logic                 div_start;
	logic [NS_W-1:0]      div_q;
	logic [PERIOD_W-1:0]  div_r;
	div_sts_t             div_sts;
	logic [NS_W-1:0]      share_x;
	logic                 active;
	logic                 split;
	logic [COUNT_W-1:0]   q_sat;
	logic                 out_load;

	function automatic logic s_pos(input logic [NS_W-1:0] v);
		return (v != '0) && !v[NS_W-1];
	endfunction

	assign cyc_now   = in_q[IN_CYCLE_NOW +: NS_W];
	assign cyc_stamp = in_q[IN_CYCLE_STAMP +: NS_W];
	assign sys_stamp = in_q[IN_SYS_STAMP +: NS_W];
	assign frac      = in_q[IN_FRAC +: FRAC_W];
	assign shamt     = in_q[IN_SHIFT +: SHIFT_W];
	assign runnable  = in_q[IN_RUNNABLE +: NS_W];
	assign blk_total = in_q[IN_BLOCKED +: NS_W];
	assign user      = in_q[IN_USER];

	assign rsh     = ~shamt + 1'b1;
	assign shifted = shamt[SHIFT_W-1] ? (d_q >> rsh) : (d_q << shamt[SHIFT_W-2:0]);
	assign mul_a   = (state_q == ST_MLO) ? d_q[FRAC_W-1:0] : d_q[NS_W-1:FRAC_W];
	assign mul_y   = NS_W'(mul_a) * NS_W'(frac);

	assign period  = (period_q == '0) ? PERIOD_W'(1) : period_q;
	assign share_x = (share_q == SH_STOLEN) ? stol_q : blkd_q;
	assign split   = (share_q == SH_STOLEN) || (share_q == SH_BLOCKED);
	assign q_sat   = (div_q[NS_W-1:COUNT_W] != '0) ? '1 : div_q[COUNT_W-1:0];

	always_comb begin
		unique case (share_q)
			SH_GLOBAL:  active = s_pos(delta_q);
			SH_STOLEN:  active = s_pos(stol_q) && s_pos(dcpu_q);
			SH_BLOCKED: active = s_pos(blkd_q) && s_pos(dcpu_q);
			SH_BUSY:    active = s_pos(dcpu_q);
			default:    active = 1'b0;
		endcase
	end

	always_comb begin
		alu_op = ALU_SUB;
		alu_a  = '0;
		alu_b  = '0;
		unique case (state_q)
			ST_DIFF:  begin alu_a = cyc_now;   alu_b = cyc_stamp; end
			ST_SCALE: begin alu_op = ALU_ADD; alu_a = prod_q; alu_b = {32'h0, lohi_q}; end
			ST_NOW:   begin alu_op = ALU_ADD; alu_a = sys_stamp; alu_b = d_q; end
			ST_DELTA: begin alu_a = now_q;     alu_b = glob_q; end
			ST_DCPU:  begin alu_a = now_q;     alu_b = loc_q; end
			ST_STOL:  begin alu_a = runnable;  alu_b = pst_q; end
			ST_BLKD:  begin alu_a = blk_total; alu_b = pbl_q; end
			ST_LIM:   begin alu_b = {32'h0, jitter_q}; end
			ST_BK1:   begin alu_a = delta_q;   alu_b = lim_q; end
			ST_BK2:   begin alu_a = dcpu_q;    alu_b = lim_q; end
			ST_CHK:   begin alu_a = share_x;   alu_b = dcpu_q; end
			ST_DSUB:  begin alu_a = dcpu_q;    alu_b = share_x; end
			ST_INC:   begin alu_a = take_q;    alu_b = {40'h0, div_r}; end
			ST_ACC1: begin
				alu_op = ALU_ADD;
				alu_b  = inc_q;
				unique case (share_q)
					SH_GLOBAL:  alu_a = glob_q;
					SH_STOLEN:  alu_a = pst_q;
					SH_BLOCKED: alu_a = pbl_q;
					SH_BUSY:    alu_a = loc_q;
					default:    alu_a = loc_q;
				endcase
			end
			ST_ACC2:  begin alu_op = ALU_ADD; alu_a = loc_q; alu_b = inc_q; end
			default:  begin alu_op = ALU_ADD; end
		endcase
	end

	vta_alu u_alu (
		.op (alu_op),
		.a  (alu_a),
		.b  (alu_b),
		.y  (alu_y),
		.lt (alu_lt)
	);

	assign div_start = (state_q == ST_DIV);

	vta_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (take_q),
		.divisor   (period),
		.quotient  (div_q),
		.remainder (div_r),
		.sts       (div_sts)
	);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign out_load      = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= TICK_PERIOD_RESET;
			jitter_q <= JITTER_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_TICK_PERIOD) begin
				period_q <= cfg_data[PERIOD_W-1:0];
			end else begin
				jitter_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			share_q     <= SH_GLOBAL;
			glob_q      <= '0;
			loc_q       <= '0;
			pst_q       <= '0;
			pbl_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= out_load || (out_valid_q && !m_axis_tready);
			unique case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						back_q  <= 1'b0;
						share_q <= SH_GLOBAL;
						for (int i = 0; i < 4; i++) begin
							res_q[i] <= '0;
						end
						if (s_axis_tuser == OP_INIT) begin
							in_q    <= {s_axis_tdata[IN_DATA_W-1:IN_USER+1], 1'b0,
								s_axis_tdata[IN_USER-1:0]};
							glob_q  <= s_axis_tdata[IN_SYS_STAMP +: NS_W];
							loc_q   <= s_axis_tdata[IN_SYS_STAMP +: NS_W];
							pst_q   <= s_axis_tdata[IN_RUNNABLE +: NS_W];
							pbl_q   <= s_axis_tdata[IN_BLOCKED +: NS_W];
							state_q <= ST_DONE;
						end else begin
							in_q    <= s_axis_tdata;
							state_q <= ST_DIFF;
						end
					end
				end
				ST_DIFF:  begin d_q <= alu_y; state_q <= ST_SHIFT; end
				ST_SHIFT: begin d_q <= shifted; state_q <= ST_MLO; end
				ST_MLO:   begin lohi_q <= mul_y[NS_W-1:FRAC_W]; state_q <= ST_MHI; end
				ST_MHI:   begin prod_q <= mul_y; state_q <= ST_SCALE; end
				ST_SCALE: begin d_q <= alu_y; state_q <= ST_NOW; end
				ST_NOW:   begin now_q <= alu_y; state_q <= ST_DELTA; end
				ST_DELTA: begin delta_q <= alu_y; state_q <= ST_DCPU; end
				ST_DCPU:  begin dcpu_q <= alu_y; state_q <= ST_STOL; end
				ST_STOL:  begin stol_q <= alu_y; state_q <= ST_BLKD; end
				ST_BLKD:  begin blkd_q <= alu_y; state_q <= ST_LIM; end
				ST_LIM:   begin lim_q <= alu_y; state_q <= ST_BK1; end
				ST_BK1:   begin back_q <= alu_lt; state_q <= ST_BK2; end
				ST_BK2:   begin back_q <= back_q | alu_lt; state_q <= ST_CHK; end
				ST_CHK: begin
					if (split) begin
						take_q <= alu_lt ? share_x : dcpu_q;
					end else if (share_q == SH_GLOBAL) begin
						take_q <= delta_q;
					end else begin
						take_q <= dcpu_q;
					end
					if (!active) begin
						if (share_q == SH_BUSY) begin
							state_q <= ST_DONE;
						end else begin
							share_q <= share_t'(share_q + 1'b1);
						end
					end else if (split) begin
						state_q <= ST_DSUB;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DSUB:  begin dcpu_q <= alu_y; state_q <= ST_DIV; end
				ST_DIV:   begin state_q <= ST_WAIT; end
				ST_WAIT: begin
					if (div_sts.done) begin
						res_q[share_q] <= q_sat;
						state_q        <= ST_INC;
					end
				end
				ST_INC:   begin inc_q <= alu_y; state_q <= ST_ACC1; end
				ST_ACC1: begin
					unique case (share_q)
						SH_GLOBAL:  glob_q <= alu_y;
						SH_STOLEN:  pst_q  <= alu_y;
						SH_BLOCKED: pbl_q  <= alu_y;
						SH_BUSY:    loc_q  <= alu_y;
						default:    loc_q  <= alu_y;
					endcase
					if (split) begin
						state_q <= ST_ACC2;
					end else if (share_q == SH_BUSY) begin
						state_q <= ST_DONE;
					end else begin
						share_q <= share_t'(share_q + 1'b1);
						state_q <= ST_CHK;
					end
				end
				ST_ACC2: begin
					loc_q   <= alu_y;
					share_q <= share_t'(share_q + 1'b1);
					state_q <= ST_CHK;
				end
				ST_DONE: begin
					if (out_load) begin
						out_data_q  <= {6'h0, back_q, user,
							res_q[SH_BUSY], res_q[SH_BLOCKED],
							res_q[SH_STOLEN], res_q[SH_GLOBAL]};
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_idle_div_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !div_sts.busy)
		else $error("divider busy while the sequencer is idle");

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_sts.done |-> (state_q == ST_WAIT))
		else $error("divider finished outside its wait state");

	a_init_load: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_INIT))
		|=> (glob_q == $past(s_axis_tdata[IN_SYS_STAMP +: NS_W]))
			&& (loc_q == glob_q))
		else $error("init command did not load the processed counters");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_virtual_tick_time_accounting.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Virtual tick time accounting testbench
// Drives timer events and init commands into the block and checks every
// result against a cycle-free model of the tick accounting. Directed tests
// cover the edge cases of the fields and the configuration. Random traffic
// then runs in several phases of input idling and output stalling, with a
// new tick period and jitter limit set in each phase.
// ----------------------------------------------------------------------------
module tb_virtual_tick_time_accounting;
	import vta_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 1500000;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned FINAL_CYCLES  = 400;

	typedef struct {
		logic        op;
		logic [63:0] cyc_now;
		logic [63:0] cyc_stamp;
		logic [63:0] sys_ns;
		logic [31:0] frac;
		logic [5:0]  shift;
		logic [63:0] run_ns;
		logic [63:0] blk_ns;
		logic        user;
	} timer_evt_t;

	typedef struct {
		logic [31:0] g_ticks;
		logic [31:0] st_ticks;
		logic [31:0] bl_ticks;
		logic [31:0] busy_ticks;
		logic        user;
		logic        back;
	} tick_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic                  s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic                  cfg_index;
	logic [JITTER_W-1:0]   cfg_data;

	logic [PERIOD_W-1:0] cfg_period = TICK_PERIOD_RESET;
	logic [JITTER_W-1:0] cfg_jitter = JITTER_RESET;
	logic [63:0]         proc_global = '0;
	logic [63:0]         proc_cpu = '0;
	logic [63:0]         proc_stolen = '0;
	logic [63:0]         proc_blocked = '0;

	logic [63:0] tl_cycle;
	logic [63:0] tl_stamp_cyc;
	logic [63:0] tl_stamp_ns;
	logic [31:0] tl_frac;
	logic [5:0]  tl_shift;
	logic [63:0] tl_run;
	logic [63:0] tl_blk;

	tick_result_t expected_ticks[$];
	int unsigned  errors = 0;
	int unsigned  cycle_count = 0;
	int unsigned  idle_pct = 0;
	int unsigned  stall_pct = 0;

	virtual_tick_time_accounting u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [63:0] scaled_ns(logic [63:0] d, logic [31:0] frac,
			logic [5:0] sh);
		logic [63:0] hi_part;
		logic [63:0] lo_part;
		if (sh[5]) begin
			d = d >> (64 - int'(sh));
		end else begin
			d = d << sh;
		end
		lo_part = {32'd0, d[31:0]} * {32'd0, frac};
		hi_part = {32'd0, d[63:32]} * {32'd0, frac};
		return hi_part + (lo_part >> 32);
	endfunction

	function automatic bit is_ahead(logic [63:0] v);
		return v != '0 && !v[63];
	endfunction

	function automatic logic [31:0] sat32(logic [63:0] v);
		return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
	endfunction

	// Updates the processed counters for one accepted transaction.
	task automatic account_event(input timer_evt_t it, output tick_result_t r);
		logic [63:0] period;
		logic [63:0] now_ns;
		logic [63:0] delta;
		logic [63:0] dcpu;
		logic [63:0] stolen;
		logic [63:0] blocked;
		logic [63:0] lim;
		logic [63:0] take;
		logic [63:0] q;
		period = (cfg_period == '0) ? 64'd1 : 64'(cfg_period);
		r = '{default: '0};
		if (it.op == OP_INIT) begin
			proc_global = it.sys_ns;
			proc_cpu = it.sys_ns;
			proc_stolen = it.run_ns;
			proc_blocked = it.blk_ns;
			return;
		end
		now_ns = it.sys_ns + scaled_ns(it.cyc_now - it.cyc_stamp, it.frac, it.shift);
		delta = now_ns - proc_global;
		dcpu = now_ns - proc_cpu;
		stolen = it.run_ns - proc_stolen;
		blocked = it.blk_ns - proc_blocked;
		lim = 64'd0 - 64'(cfg_jitter);
		r.back = ($signed(delta) < $signed(lim)) || ($signed(dcpu) < $signed(lim));
		if (is_ahead(delta) && delta >= period) begin
			q = delta / period;
			proc_global = proc_global + q * period;
			r.g_ticks = sat32(q);
		end
		if (is_ahead(stolen) && is_ahead(dcpu)) begin
			take = (stolen < dcpu) ? stolen : dcpu;
			dcpu = dcpu - stolen;
			q = take / period;
			proc_stolen = proc_stolen + q * period;
			proc_cpu = proc_cpu + q * period;
			r.st_ticks = sat32(q);
		end
		if (is_ahead(blocked) && is_ahead(dcpu)) begin
			take = (blocked < dcpu) ? blocked : dcpu;
			dcpu = dcpu - blocked;
			q = take / period;
			proc_blocked = proc_blocked + q * period;
			proc_cpu = proc_cpu + q * period;
			r.bl_ticks = sat32(q);
		end
		if (is_ahead(dcpu)) begin
			q = dcpu / period;
			proc_cpu = proc_cpu + q * period;
			r.busy_ticks = sat32(q);
		end
		r.user = it.user;
	endtask

	function automatic timer_evt_t rand_item();
		timer_evt_t it;
		it.op = ($urandom_range(99) < 10) ? OP_INIT : OP_TIMER;
		it.cyc_now = rand64();
		it.cyc_stamp = rand64();
		it.sys_ns = rand64();
		it.frac = $urandom;
		it.shift = 6'($urandom);
		it.run_ns = rand64();
		it.blk_ns = rand64();
		it.user = 1'($urandom);
		return it;
	endfunction

	function automatic timer_evt_t make_init(logic [63:0] sys_ns, logic [63:0] run_ns,
			logic [63:0] blk_ns, logic user);
		timer_evt_t it;
		it = rand_item();
		it.op = OP_INIT;
		it.sys_ns = sys_ns;
		it.run_ns = run_ns;
		it.blk_ns = blk_ns;
		it.user = user;
		return it;
	endfunction

	// A timer event whose time base maps one cycle to one nanosecond.
	function automatic timer_evt_t make_event(logic [63:0] ns, logic [63:0] run_ns,
			logic [63:0] blk_ns, logic user);
		timer_evt_t it;
		it.op = OP_TIMER;
		it.cyc_now = ns;
		it.cyc_stamp = '0;
		it.sys_ns = '0;
		it.frac = 32'h8000_0000;
		it.shift = 6'd1;
		it.run_ns = run_ns;
		it.blk_ns = blk_ns;
		it.user = user;
		return it;
	endfunction

	task automatic push_event(input timer_evt_t it);
		tick_result_t r;
		while ($urandom_range(99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= it.op;
		s_axis_tdata <= {1'b0, it.user, it.blk_ns, it.run_ns, it.shift, it.frac,
			it.sys_ns, it.cyc_stamp, it.cyc_now};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		account_event(it, r);
		expected_ticks.push_back(r);
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (expected_ticks.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [JITTER_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == CFG_TICK_PERIOD) begin
			cfg_period = data[PERIOD_W-1:0];
		end else begin
			cfg_jitter = data;
		end
	endtask

	task automatic set_config(input logic [PERIOD_W-1:0] period,
			input logic [JITTER_W-1:0] jitter);
		wait_idle();
		write_reg(CFG_TICK_PERIOD, {8'($urandom), period});
		write_reg(CFG_JITTER, jitter);
		cfg_valid <= 1'b0;
	endtask

	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin : result_check
		tick_result_t exp_r;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_ticks.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time,
					m_axis_tdata);
				errors++;
			end else begin
				exp_r = expected_ticks.pop_front();
				compare_field("global_ticks", exp_r.g_ticks, m_axis_tdata[31:0]);
				compare_field("stolen_ticks", exp_r.st_ticks, m_axis_tdata[63:32]);
				compare_field("blocked_ticks", exp_r.bl_ticks, m_axis_tdata[95:64]);
				compare_field("busy_ticks", exp_r.busy_ticks, m_axis_tdata[127:96]);
				compare_field("busy_is_user", 32'(exp_r.user), 32'(m_axis_tdata[128]));
				compare_field("went_backwards", 32'(exp_r.back), 32'(m_axis_tdata[129]));
			end
		end
	end

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("virtual_tick_time_accounting verification failed");
			$finish;
		end
	end

	task automatic test_basic_accounting();
		push_event(make_init(64'd1000, 64'd0, 64'd0, 1'b1));
		push_event(make_event(64'd30_000_000, 64'd5_000_000, 64'd12_000_000, 1'b1));
		push_event(make_event(64'd60_000_000, 64'd100_000_000, 64'd12_000_000, 1'b0));
		push_event(make_event(64'd65_000_000, 64'd100_000_000, 64'd200_000_000, 1'b1));
		push_event(make_event(64'd65_000_000, 64'd100_000_000, 64'd200_000_000, 1'b1));
	endtask

	task automatic test_time_backwards();
		push_event(make_init(64'd100_000_000, 64'd0, 64'd0, 1'b0));
		push_event(make_event(64'd90_000_000, 64'd0, 64'd0, 1'b0));
		push_event(make_event(64'd89_999_999, 64'd0, 64'd0, 1'b1));
		push_event(make_event(64'd0, 64'd0, 64'd0, 1'b0));
	endtask

	task automatic test_field_extremes();
		timer_evt_t it;
		it = '{op: OP_TIMER, cyc_now: '1, cyc_stamp: '1, sys_ns: '1, frac: '1, shift: '1,
			run_ns: '1, blk_ns: '1, user: 1'b1};
		push_event(it);
		it = '{default: '0};
		it.op = OP_TIMER;
		push_event(it);
		push_event(make_init('1, '1, '1, 1'b1));
		it = rand_item();
		it.op = OP_TIMER;
		it.shift = 6'd31;
		push_event(it);
		it.shift = 6'b100000;
		push_event(it);
		it.shift = 6'd0;
		it.frac = '0;
		push_event(it);
		it.frac = '1;
		it.cyc_stamp = '0;
		it.cyc_now = '1;
		push_event(it);
		push_event(make_init('0, '0, '0, 1'b0));
	endtask

	task automatic test_period_extremes();
		set_config('0, '0);
		push_event(make_event(64'd5, 64'd2, 64'd1, 1'b1));
		push_event(make_event(64'd4, 64'd2, 64'd1, 1'b0));
		set_config(24'd1, 32'hFFFF_FFFF);
		push_event(make_init('0, '0, '0, 1'b0));
		push_event(make_event(64'h100_0000_0000, 64'h10_0000_0000, 64'h20_0000_0000, 1'b1));
		push_event(make_event(64'h100_0000_0000 - 64'h2_0000_0000, '0, '0, 1'b0));
		set_config(24'hFF_FFFF, 32'd0);
		push_event(make_event(64'h8000_0000_0000, 64'h1_0000_0000, 64'h1_0000_0000, 1'b1));
	endtask

	// Mostly well-formed accounting runs that start from an init command,
	// mixed with fully random transactions.
	task automatic test_random_traffic(input int unsigned idle, input int unsigned stall,
			input logic [PERIOD_W-1:0] period, input logic [JITTER_W-1:0] jitter,
			input int unsigned n_items);
		int unsigned sent;
		int unsigned len;
		int unsigned adv_max;
		int unsigned adv;
		timer_evt_t it;
		set_config(period, jitter);
		idle_pct = idle;
		stall_pct = stall;
		adv_max = (period < 24'd1000) ? 5000 : 5 * int'(period);
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(99) < 15) begin
				push_event(rand_item());
				sent++;
			end else begin
				tl_stamp_ns = ($urandom_range(1)) ? rand64() : 64'($urandom);
				tl_stamp_cyc = rand64();
				tl_cycle = tl_stamp_cyc;
				tl_run = rand64();
				tl_blk = rand64();
				case ($urandom_range(3))
					0: begin
						tl_frac = 32'h8000_0000;
						tl_shift = 6'd1;
					end
					1: begin
						tl_frac = $urandom_range(32'hFFFF_FFFF, 32'h4000_0000);
						tl_shift = 6'd0;
					end
					2: begin
						tl_frac = $urandom | 32'h8000_0000;
						tl_shift = 6'h3F;
					end
					default: begin
						tl_frac = $urandom;
						tl_shift = 6'($urandom_range(3));
					end
				endcase
				push_event(make_init(tl_stamp_ns, tl_run, tl_blk, 1'($urandom)));
				sent++;
				len = $urandom_range(16, 4);
				for (int k = 0; k < len && sent < n_items; k++) begin
					adv = $urandom_range(adv_max, 0);
					tl_cycle = tl_cycle + 64'(adv);
					if ($urandom_range(1)) tl_run = tl_run + 64'($urandom_range(adv_max / 2, 0));
					if ($urandom_range(1)) tl_blk = tl_blk + 64'($urandom_range(adv_max / 2, 0));
					if ($urandom_range(99) < 10) begin
						tl_stamp_ns = tl_stamp_ns +
							scaled_ns(tl_cycle - tl_stamp_cyc, tl_frac, tl_shift);
						tl_stamp_cyc = tl_cycle;
					end
					it.op = OP_TIMER;
					it.cyc_now = tl_cycle;
					if ($urandom_range(99) < 8)
						it.cyc_now = tl_cycle - 64'($urandom_range(3 * adv_max, 0));
					it.cyc_stamp = tl_stamp_cyc;
					it.sys_ns = tl_stamp_ns;
					it.frac = tl_frac;
					it.shift = tl_shift;
					it.run_ns = tl_run;
					it.blk_ns = tl_blk;
					it.user = 1'($urandom);
					push_event(it);
					sent++;
				end
			end
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= OP_TIMER;
		m_axis_tready <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_TICK_PERIOD;
		cfg_data <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		idle_pct = 13;
		stall_pct = 13;
		test_basic_accounting();
		test_time_backwards();
		test_field_extremes();
		test_period_extremes();
		test_random_traffic(0, 0, TICK_PERIOD_RESET, JITTER_RESET, 163);
		test_random_traffic(54, 0, 24'd1_000_000, 32'd0, 163);
		test_random_traffic(0, 54, 24'hFF_FFFF, 32'hFFFF_FFFF, 163);
		test_random_traffic(13, 13, 24'd1, 32'd5000, 163);
		wait_idle();
		repeat (FINAL_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("virtual_tick_time_accounting verification clean");
		end else begin
			$display("virtual_tick_time_accounting verification failed");
		end
		$finish;
	end

endmodule
